// ----- rtl/kri_pkg.sv -----
// ----------------------------------------------------------------------------
// kri_pkg
// shared types and codes for the key/record multimap index
// ----------------------------------------------------------------------------
package kri_pkg;

    localparam int ENTRIES_DEF   = 64;
    localparam int KEY_W         = 64;
    localparam int REC_W         = 32;
    localparam int STATUS_W      = 3;
    localparam int ENTRY_COUNT_W = 7;

    // action codes on the input
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_ERASE  = 2'd1;
    localparam logic [1:0] ACT_FIND   = 2'd2;

    // status codes on the result
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOKEY = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOREC = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_ERASE,
        OP_FIND,
        OP_NOP
    } op_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [KEY_W-1:0] key;
        logic [REC_W-1:0] rec_id;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic                     has_record;
        logic [REC_W-1:0]         record_out;
        logic                     last;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } out_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [REC_W-1:0] rec;
    } cmd_t;

    typedef struct packed {
        logic                     busy;
        logic [ENTRY_COUNT_W-1:0] count;
    } eng_stat_t;

endpackage

// ----- rtl/kri_ram.sv -----
// ----------------------------------------------------------------------------
// kri_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module kri_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // read data holds while re is low
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/kri_front.sv -----
// ----------------------------------------------------------------------------
// kri_front
// input queue: accepts items, decodes the action, holds two commands
// ----------------------------------------------------------------------------
module kri_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  kri_pkg::in_t  item,
    output logic          cmd_vld,
    output kri_pkg::cmd_t cmd,
    input  logic          cmd_take
);
    import kri_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       dec;
    logic       do_push;
    logic       do_pop;

    // classify the action
    always_comb
    begin
        dec.key = item.key;
        dec.rec = item.rec_id;
        unique case (item.action)
            ACT_INSERT: dec.op = OP_INSERT;
            ACT_ERASE:  dec.op = OP_ERASE;
            ACT_FIND:   dec.op = OP_FIND;
            default:    dec.op = OP_NOP;
        endcase
    end

    assign full    = (cnt_reg == 2'd2);
    assign cmd_vld = (cnt_reg != 2'd0);
    assign cmd     = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = cmd_take && cmd_vld;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- rtl/kri_engine.sv -----
// ----------------------------------------------------------------------------
// kri_engine
// scans the pair store one entry a cycle while no find stalls on the result, shifts on erase, emits results
// ----------------------------------------------------------------------------
module kri_engine #(
    parameter int ENTRIES = kri_pkg::ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_vld,
    input  kri_pkg::cmd_t      cmd,
    output logic               cmd_take,
    output logic               empty,
    input  logic               pop,
    output kri_pkg::out_t      result,
    output kri_pkg::eng_stat_t stat
);
    import kri_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int DATA_W = KEY_W + REC_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] iss_reg, iss_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [CNT_W-1:0] chk_idx_reg, chk_idx_next;
    logic             dup_reg, dup_next;
    logic             seen_reg, seen_next;
    logic             found_reg, found_next;
    logic             pend_vld_reg, pend_vld_next;
    logic [REC_W-1:0] pend_rec_reg, pend_rec_next;
    logic             out_vld_reg, out_vld_next;
    out_t             out_reg, out_next;

    logic              re, we;
    logic [IDX_W-1:0]  raddr, waddr;
    logic [DATA_W-1:0] wdata, rdata;
    logic [KEY_W-1:0]  ram_key;
    logic [REC_W-1:0]  ram_rec;
    logic              key_hit, pair_hit, out_free, stall, erase_hit, issue;
    logic              emit;
    out_t              emit_data;
    logic [ENTRY_COUNT_W-1:0] cnt_ext;

    kri_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign ram_key   = rdata[DATA_W-1:REC_W];
    assign ram_rec   = rdata[REC_W-1:0];
    assign key_hit   = chk_vld_reg && (ram_key == cmd_reg.key);
    assign pair_hit  = key_hit && (ram_rec == cmd_reg.rec);
    assign out_free  = !out_vld_reg || pop;
    assign cnt_ext   = ENTRY_COUNT_W'(count_reg);
    assign issue     = (iss_reg < count_reg);
    assign stall     = (cmd_reg.op == OP_FIND) && key_hit && pend_vld_reg && !out_free;
    assign erase_hit = (cmd_reg.op == OP_ERASE) && pair_hit;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        count_next    = count_reg;
        iss_next      = iss_reg;
        chk_vld_next  = chk_vld_reg;
        chk_idx_next  = chk_idx_reg;
        dup_next      = dup_reg;
        seen_next     = seen_reg;
        found_next    = found_reg;
        pend_vld_next = pend_vld_reg;
        pend_rec_next = pend_rec_reg;
        cmd_take      = 1'b0;
        re            = 1'b0;
        raddr         = iss_reg[IDX_W-1:0];
        we            = 1'b0;
        waddr         = count_reg[IDX_W-1:0];
        wdata         = {cmd_reg.key, cmd_reg.rec};
        emit          = 1'b0;
        emit_data     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_vld)
                begin
                    cmd_take      = 1'b1;
                    cmd_next      = cmd;
                    iss_next      = '0;
                    chk_vld_next  = 1'b0;
                    dup_next      = 1'b0;
                    seen_next     = 1'b0;
                    found_next    = 1'b0;
                    pend_vld_next = 1'b0;
                    state_next    = (cmd.op == OP_NOP) ? S_FIN : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (erase_hit)
                begin
                    // close the gap: move every later entry down by one
                    found_next   = 1'b1;
                    iss_next     = chk_idx_reg + CNT_W'(1);
                    chk_vld_next = 1'b0;
                    state_next   = S_SHIFT;
                end
                else if (!stall)
                begin
                    re           = issue;
                    chk_vld_next = issue;
                    chk_idx_next = iss_reg;
                    if (issue)
                    begin
                        iss_next = iss_reg + CNT_W'(1);
                    end
                    if (pair_hit)
                    begin
                        dup_next = 1'b1;
                    end
                    if (key_hit)
                    begin
                        seen_next = 1'b1;
                    end
                    if ((cmd_reg.op == OP_FIND) && key_hit)
                    begin
                        // the held hit is not the last one any more
                        if (pend_vld_reg)
                        begin
                            emit                 = 1'b1;
                            emit_data.status     = ST_OK;
                            emit_data.has_record = 1'b1;
                            emit_data.record_out = pend_rec_reg;
                            emit_data.entry_count = cnt_ext;
                        end
                        pend_vld_next = 1'b1;
                        pend_rec_next = ram_rec;
                    end
                    if (!issue && !chk_vld_reg)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_SHIFT:
            begin
                if (chk_vld_reg)
                begin
                    we    = 1'b1;
                    waddr = IDX_W'(chk_idx_reg - CNT_W'(1));
                    wdata = rdata;
                end
                re           = issue;
                chk_vld_next = issue;
                chk_idx_next = iss_reg;
                if (issue)
                begin
                    iss_next = iss_reg + CNT_W'(1);
                end
                if (!issue && !chk_vld_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    emit                  = 1'b1;
                    emit_data.status      = ST_OK;
                    emit_data.last        = 1'b1;
                    emit_data.entry_count = cnt_ext;
                    state_next            = S_IDLE;
                    case (cmd_reg.op)
                        OP_INSERT:
                        begin
                            if (dup_reg)
                            begin
                                emit_data.status = ST_DUP;
                            end
                            else if (count_reg >= CNT_W'(ENTRIES))
                            begin
                                emit_data.status = ST_FULL;
                            end
                            else
                            begin
                                we                    = 1'b1;
                                count_next            = count_reg + CNT_W'(1);
                                emit_data.entry_count = ENTRY_COUNT_W'(count_next);
                            end
                        end
                        OP_ERASE:
                        begin
                            if (!found_reg)
                            begin
                                emit_data.status = seen_reg ? ST_NOREC : ST_NOKEY;
                            end
                        end
                        OP_FIND:
                        begin
                            emit_data.has_record = pend_vld_reg;
                            emit_data.record_out = pend_vld_reg ? pend_rec_reg : '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_vld_next = out_vld_reg && !pop;
        out_next     = out_reg;
        if (emit)
        begin
            out_vld_next = 1'b1;
            out_next     = emit_data;
        end
    end

    assign empty       = !out_vld_reg;
    assign result      = out_reg;
    assign stat.busy   = (state_reg != S_IDLE);
    assign stat.count  = cnt_ext;

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        chk_idx_reg  <= chk_idx_next;
        pend_rec_reg <= pend_rec_next;
        out_reg      <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            iss_reg      <= '0;
            chk_vld_reg  <= 1'b0;
            dup_reg      <= 1'b0;
            seen_reg     <= 1'b0;
            found_reg    <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            iss_reg      <= iss_next;
            chk_vld_reg  <= chk_vld_next;
            dup_reg      <= dup_next;
            seen_reg     <= seen_next;
            found_reg    <= found_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

endmodule

// ----- rtl/key_record_multimap_index.sv -----
// ----------------------------------------------------------------------------
// key_record_multimap_index
// bounded multimap from 64-bit keys to 32-bit record ids, kept in insertion order
// ----------------------------------------------------------------------------
// usage
//   input side is a queue: drive item and push, a transaction completes when
//   push is high and full is low; a two-deep command queue takes items while
//   the engine is busy
//   result side is a queue: the oldest result sits on result while empty is
//   low, a transaction completes when pop is high and empty is low
//   insert and erase give one result, find gives one result per stored record
//   of the key (oldest first, last set on the final one) or one empty result
// scan
//   the store has one read port and is scanned one entry a cycle while no
//   find stalls on the result; an erase that hits stops its scan there and
//   shifts the later entries down; the engine takes the next item only
//   once it is done with the last and has registered its final result
// reset
//   entry count, queues and engine clear at once; no clearing pass is run
// stalls
//   when pop stays low the engine holds its scan until the result register
//   frees up; the input queue keeps taking items until it fills
// ----------------------------------------------------------------------------
module key_record_multimap_index #(
    parameter int ENTRIES = kri_pkg::ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  kri_pkg::in_t  item,
    output logic          empty,
    input  logic          pop,
    output kri_pkg::out_t result
);
    import kri_pkg::*;

    // command handoff between queue and engine
    logic      cmd_vld;
    logic      cmd_take;
    cmd_t      cmd;
    eng_stat_t stat;

    // front: accept and decode
    kri_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .cmd_vld  (cmd_vld),
        .cmd      (cmd),
        .cmd_take (cmd_take)
    );

    // back: scan, shift, emit
    kri_engine #(
        .ENTRIES (ENTRIES)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_vld  (cmd_vld),
        .cmd      (cmd),
        .cmd_take (cmd_take),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .stat     (stat)
    );

`ifndef SYNTHESIS
    // live count stays within the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= ENTRY_COUNT_W'(ENTRIES))
        else $error("entry count above store size");

    // only find hits come out without last
    a_nonlast_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !result.last |-> result.has_record)
        else $error("non-final result without a record");

    // a found record always reports ok
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.has_record |-> result.status == ST_OK)
        else $error("record result with error status");

    // an idle engine has delivered its final transaction
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        !stat.busy && !empty |-> result.last)
        else $error("engine idle with a partial result pending");
`endif

endmodule

// ----- dv/key_record_multimap_index_checker.sv -----
// ----------------------------------------------------------------------------
// key_record_multimap_index_checker
// watches both queue sides of the index, keeps its own copy of the store and
// compares every popped result, field by field, with the oldest prediction
// ----------------------------------------------------------------------------
module key_record_multimap_index_checker #(
    parameter int ENTRIES = kri_pkg::ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic          full,
    input  kri_pkg::in_t  item,
    input  logic          empty,
    input  logic          pop,
    input  kri_pkg::out_t result,
    output int            fail_count,
    output int            outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    import kri_pkg::*;

    logic [KEY_W-1:0] key_slot [ENTRIES];
    logic [REC_W-1:0] rec_slot [ENTRIES];
    int               pair_count = 0;
    out_t             expected_q [$];
    int               fails = 0;

    assign fail_count = fails;

    function automatic out_t make_result(logic [STATUS_W-1:0] status, logic has,
                                         logic [REC_W-1:0] rec, logic last);
        out_t r;
        r.status      = status;
        r.has_record  = has;
        r.record_out  = rec;
        r.last        = last;
        r.entry_count = pair_count[ENTRY_COUNT_W-1:0];
        return r;
    endfunction

    // append one prediction at the tail
    task automatic enqueue_expected(out_t r);
        expected_q.insert(expected_q.size(), r);
    endtask

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            fails++;
            $display("%0t checker: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // apply one accepted transaction to the shadow store, queue its results
    task automatic predict(in_t it);
        int                  hit;
        int                  last_hit;
        bit                  key_seen;
        logic [STATUS_W-1:0] status;
        case (it.action)
            ACT_INSERT:
            begin
                status = ST_OK;
                for (int i = 0; i < pair_count; i++)
                    if (key_slot[i] == it.key && rec_slot[i] == it.rec_id)
                        status = ST_DUP;
                // duplicate wins over full
                if (status == ST_OK && pair_count >= ENTRIES)
                    status = ST_FULL;
                if (status == ST_OK)
                begin
                    key_slot[pair_count] = it.key;
                    rec_slot[pair_count] = it.rec_id;
                    pair_count++;
                end
                enqueue_expected(make_result(status, 1'b0, '0, 1'b1));
            end
            ACT_ERASE:
            begin
                hit      = -1;
                key_seen = 1'b0;
                for (int i = 0; i < pair_count; i++)
                    if (key_slot[i] == it.key)
                    begin
                        key_seen = 1'b1;
                        if (hit < 0 && rec_slot[i] == it.rec_id)
                            hit = i;
                    end
                if (hit >= 0)
                begin
                    // close the gap, survivors keep their order
                    for (int j = hit; j < pair_count - 1; j++)
                    begin
                        key_slot[j] = key_slot[j + 1];
                        rec_slot[j] = rec_slot[j + 1];
                    end
                    pair_count--;
                    status = ST_OK;
                end
                else
                    status = key_seen ? ST_NOREC : ST_NOKEY;
                enqueue_expected(make_result(status, 1'b0, '0, 1'b1));
            end
            ACT_FIND:
            begin
                last_hit = -1;
                for (int i = 0; i < pair_count; i++)
                    if (key_slot[i] == it.key)
                        last_hit = i;
                if (last_hit < 0)
                    enqueue_expected(make_result(ST_OK, 1'b0, '0, 1'b1));
                else
                    for (int i = 0; i <= last_hit; i++)
                        if (key_slot[i] == it.key)
                            enqueue_expected(make_result(ST_OK, 1'b1, rec_slot[i],
                                                         i == last_hit));
            end
            default:
                enqueue_expected(make_result(ST_OK, 1'b0, '0, 1'b1));
        endcase
    endtask

    task automatic check_result(out_t got);
        out_t want;
        if (expected_q.size() == 0)
        begin
            fails++;
            $display("%0t checker: result expected none actual status %0d record %0h",
                     $time, got.status, got.record_out);
            return;
        end
        want = expected_q.pop_front();
        check_field("status", want.status, got.status);
        check_field("has_record", want.has_record, got.has_record);
        check_field("record_out", want.record_out, got.record_out);
        check_field("last", want.last, got.last);
        check_field("entry_count", want.entry_count, got.entry_count);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                check_result(result);
            if (push && !full)
                predict(item);
        end
        outstanding <= expected_q.size();
    end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives insert, erase and find transactions into the multimap index with
// bursty input and a stalling result side; a checker beside the block
// predicts every result and counts mismatches, the top gives the verdict
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import kri_pkg::*;

    localparam int ITEM_TARGET  = 410;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 600;      // one long result-side hold-off
    localparam int TAIL_CYCLES  = 140;      // about two full scans plus slack
    localparam int FILL_INSERTS = 70;       // more than ENTRIES, forces table full

    // the fourth action code, which the block must ignore
    localparam logic [1:0] ACT_UNUSED = 2'(OP_NOP);

    logic  clk;
    logic  rst_n;
    logic  push;
    logic  full;
    in_t   item;
    logic  empty;
    logic  pop;
    out_t  result;

    int    fail_count;
    int    outstanding;
    int    accepted_items = 0;
    int    burst_left = 0;
    int    cycle_count;

    // small pools so that keys and pairs collide often
    logic [KEY_W-1:0] key_pool [8];
    logic [REC_W-1:0] rec_pool [8];

    // pairs sent as inserts, used to aim erases at live entries
    in_t inserted_q [$];

    key_record_multimap_index dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    key_record_multimap_index_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item        (item),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly pool values, now and then a fully random one
    function automatic logic [KEY_W-1:0] pool_key();
        return ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                            : key_pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic [REC_W-1:0] pool_rec();
        return ($urandom_range(0, 9) == 0) ? $urandom : rec_pool[$urandom_range(0, 7)];
    endfunction

    // one transaction on the input side; push stays high across a burst and
    // drops for a random gap once the burst runs out
    task automatic send(input logic [1:0] act, input logic [KEY_W-1:0] k,
                        input logic [REC_W-1:0] r);
        in_t logged;
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            // long bursts give stretches without any input idling
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        item <= '{action: act, key: k, rec_id: r};
        push <= 1'b1;
        burst_left--;
        // wait for the transaction to complete: push high, full low at the edge
        do @(posedge clk); while (full);
        accepted_items++;
        if (act == ACT_INSERT && inserted_q.size() < 128)
        begin
            logged = '{action: act, key: k, rec_id: r};
            inserted_q.insert(inserted_q.size(), logged);
        end
    endtask

    // sender pause until every predicted result has been popped
    task automatic drain_results();
        push <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic erase_logged(int idx);
        in_t pick;
        pick = inserted_q[idx];
        inserted_q.delete(idx);
        send(ACT_ERASE, pick.key, pick.rec_id);
    endtask

    // random mix: inserts, erases mostly aimed at live pairs, finds, noise
    task automatic send_mixed();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            send(ACT_INSERT, pool_key(), pool_rec());
        else if (roll < 70)
        begin
            if (inserted_q.size() > 0 && $urandom_range(0, 9) < 7)
                erase_logged($urandom_range(0, inserted_q.size() - 1));
            else
                send(ACT_ERASE, pool_key(), pool_rec());
        end
        else if (roll < 95)
            send(ACT_FIND, pool_key(), $urandom);
        else
            send(ACT_UNUSED, pool_key(), $urandom);
    endtask

    // well-formed cleanup: erase oldest logged pairs, then look keys up
    task automatic sweep_inserted();
        int n;
        n = $urandom_range(10, 40);
        while (n > 0 && inserted_q.size() > 0)
        begin
            erase_logged(0);
            n--;
        end
        for (int i = 0; i < 8; i += 2)
            send(ACT_FIND, key_pool[i], $urandom);
    endtask

    initial
    begin : stimulus
        logic [KEY_W-1:0] k_a;
        logic [KEY_W-1:0] fill_key;
        logic [REC_W-1:0] r_one;
        logic [REC_W-1:0] r_miss;
        int               phase;

        rst_n = 1'b0;
        push <= 1'b0;
        item <= '0;

        key_pool[0] = '0;
        key_pool[1] = '1;
        rec_pool[0] = '0;
        rec_pool[1] = '1;
        for (int i = 2; i < 8; i++)
        begin
            key_pool[i] = {$urandom, $urandom};
            rec_pool[i] = $urandom;
        end
        // neither all zeros nor all ones, and r_miss is never stored
        k_a    = {32'h0, $urandom} | 64'h1;
        r_one  = $urandom_range(2, 32'hffff_fffd);
        r_miss = r_one ^ 32'h1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, leaves the store empty again
        send(ACT_FIND, '0, '0);         // lookup on an empty store
        send(ACT_ERASE, '0, '0);        // key not found
        send(ACT_INSERT, '0, '0);
        send(ACT_INSERT, '0, '0);       // duplicate pair
        send(ACT_INSERT, '1, '1);
        send(ACT_INSERT, '0, '1);
        send(ACT_INSERT, k_a, r_one);
        send(ACT_INSERT, '0, r_one);
        send(ACT_FIND, '0, '1);         // three records, oldest first
        send(ACT_ERASE, '0, r_miss);    // key present, record absent
        send(ACT_ERASE, '0, '1);        // erase from the middle, shift down
        send(ACT_FIND, '0, $urandom);
        send(ACT_UNUSED, '1, '1);       // ignored action code
        send(ACT_FIND, '1, '0);
        send(ACT_ERASE, '1, '1);
        send(ACT_ERASE, '1, '1);        // key gone now
        send(ACT_ERASE, '0, '0);        // erase the head slot
        send(ACT_ERASE, k_a, r_one);
        send(ACT_ERASE, '0, r_one);     // erase the tail slot
        send(ACT_FIND, k_a, '1);
        drain_results();
        inserted_q.delete();

        // fill one key past capacity: table full, then a find with up to
        // ENTRIES results, then scattered erases that shift the store
        fill_key = {$urandom, $urandom};
        repeat (FILL_INSERTS) send(ACT_INSERT, fill_key, $urandom);
        send(ACT_FIND, fill_key, $urandom);
        repeat (20) erase_logged($urandom_range(0, inserted_q.size() - 1));
        send(ACT_FIND, fill_key, $urandom);

        phase = 0;
        while (accepted_items < ITEM_TARGET)
        begin
            phase++;
            if (phase % 3 == 0)
                sweep_inserted();
            else
                repeat ($urandom_range(20, 50)) send_mixed();
            if (phase == 4)
                drain_results();
        end

        drain_results();
        // catch any stray result the block might still produce
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // result side: stretches of free popping, random popping and a one in
    // four pattern, plus a single long hold-off so the block backs up
    initial
    begin : receiver
        int         mode;
        int         span;
        logic [1:0] beat;
        bit         held_off;

        pop <= 1'b0;
        held_off = 1'b0;
        beat = '0;
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 150);
            repeat (span)
            begin
                @(posedge clk);
                if (!held_off && accepted_items >= 25)
                begin
                    // sender keeps going during the fill phase meanwhile
                    held_off = 1'b1;
                    pop <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                beat++;
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    default: pop <= (beat == 2'd0);
                endcase
            end
        end
    end

    // hard stop in case the block hangs
    initial
    begin : watchdog
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("testbench: errors");
        $finish;
    end

endmodule
